[design/sha_pkg.sv]
// Shared types and constants of the SHA-256 byte stream hasher.
package sha_pkg;

  typedef logic [15:0][31:0] blk_t;
  typedef logic [7:0][31:0]  hash_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_BYTE_FIN = 2'd1;
  localparam logic [1:0] KIND_FIN      = 2'd2;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

[design/sha_fifo.sv]
// Small register queue used between the front, the back and the result side.
module sha_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

[design/sha_core.sv]
// Iterative SHA-256 compression unit, one round per cycle.
module sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sha_pkg::blk_t       block_i,
  input  sha_pkg::hash_t      chain_i,
  output sha_pkg::hash_t      vars_o,
  output sha_pkg::core_stat_t stat_o
);
  import sha_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w_q [16];
  hash_t       v_q;
  logic [5:0]  round_q;
  logic        busy_q, done_q;
  logic [31:0] t1, t2, w_new, s0, s1, bs0, bs1, ch, maj;

  assign bs1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign bs0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + bs1 + ch + ROUND_K[round_q] + w_q[0];
  assign t2    = bs0 + maj;
  assign s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = s1 + w_q[9] + s0 + w_q[0];

  assign vars_o      = v_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        round_q <= '0;
      end else if (busy_q) begin
        round_q <= round_q + 6'd1;
        if (round_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= chain_i;
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[i];
      end
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
    end
  end

endmodule

[design/sha_engine.sv]
// Back end: byte packing, padding, chaining update and digest emission.
module sha_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sha_pkg::in_item_t   in_item_i,
  output logic                in_pop_o,
  output logic                core_start_o,
  output sha_pkg::blk_t       block_o,
  output sha_pkg::hash_t      chain_o,
  input  sha_pkg::hash_t      vars_i,
  input  sha_pkg::core_stat_t core_stat_i,
  input  logic                out_full_i,
  output logic                out_push_o,
  output sha_pkg::out_item_t  out_item_o
);
  import sha_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_PAD  = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]  state_q, after_q;
  logic        go_q;
  blk_t        blk_q;
  hash_t       chain_q;
  logic [5:0]  cnt_q;
  logic [63:0] len_q;
  logic [2:0]  idx_q;
  logic [31:0] byte_word, pad_word;
  logic [4:0]  shift;

  assign shift     = {~cnt_q[1:0], 3'b000};
  assign byte_word = {24'd0, in_item_i.data_byte} << shift;
  assign pad_word  = {24'd0, 8'h80} << shift;

  assign in_pop_o     = (state_q == ST_IDLE) && in_valid_i;
  assign core_start_o = go_q;
  assign block_o      = blk_q;
  assign chain_o      = chain_q;
  assign out_push_o   = (state_q == ST_EMIT) && !out_full_i;

  assign out_item_o.digest_word = chain_q[idx_q];
  assign out_item_o.word_index  = idx_q;
  assign out_item_o.last_word   = (idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= ST_IDLE;
      go_q    <= 1'b0;
      blk_q   <= '0;
      chain_q <= INIT_HASH;
      cnt_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
    end else begin
      go_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (in_item_i.kind == KIND_FIN) begin
              state_q <= ST_PAD;
            end else begin
              blk_q[cnt_q[5:2]] <= blk_q[cnt_q[5:2]] | byte_word;
              cnt_q <= cnt_q + 6'd1;
              len_q <= len_q + 64'd8;
              if (cnt_q == 6'd63) begin
                go_q    <= 1'b1;
                state_q <= ST_COMP;
                after_q <= (in_item_i.kind == KIND_BYTE_FIN) ? ST_PAD : ST_IDLE;
              end else if (in_item_i.kind == KIND_BYTE_FIN) begin
                state_q <= ST_PAD;
              end
            end
          end
        end
        ST_PAD: begin
          blk_q[cnt_q[5:2]] <= blk_q[cnt_q[5:2]] | pad_word;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q >= 6'd56) begin
            go_q    <= 1'b1;
            state_q <= ST_COMP;
            after_q <= ST_LEN;
          end else begin
            state_q <= ST_LEN;
          end
        end
        ST_LEN: begin
          blk_q[14] <= len_q[63:32];
          blk_q[15] <= len_q[31:0];
          go_q      <= 1'b1;
          state_q   <= ST_COMP;
          after_q   <= ST_EMIT;
        end
        ST_COMP: begin
          if (core_stat_i.done) begin
            for (int i = 0; i < 8; i++) begin
              chain_q[i] <= chain_q[i] + vars_i[i];
            end
            blk_q   <= '0;
            cnt_q   <= '0;
            idx_q   <= '0;
            state_q <= after_q;
          end
        end
        ST_EMIT: begin
          if (!out_full_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              chain_q <= INIT_HASH;
              len_q   <= '0;
              cnt_q   <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[design/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream: input queue, packing/padding engine, round unit, result queue.
//
// Input channel: present kind and data_byte on in_i with push high; the request is taken
// at a rising edge where push is high and full is low. kind 0 appends a byte, kind 1
// appends a byte and finishes the message, kind 2 finishes without a byte; kind 3 is
// taken and dropped. Requests wait in an InDepth-entry queue ahead of the engine.
// Throughput: one byte per cycle while the engine is idle. Each completed 64-byte block
// holds the engine while the round unit loads it and runs its 64 rounds, one per cycle,
// and for the chaining add. A finish costs one or two such compressions plus the pad and
// length states, then emits eight digest words, holding while the result queue is full.
// Result channel: while empty is low, out_o holds the oldest digest word (word_index 0
// first, last_word on the eighth); pop high at a rising edge takes it. Results wait in
// an OutDepth-entry queue; when it is full the engine holds, and the input queue keeps
// taking requests until it too fills and raises full.
// Reset (rst_ni low, asynchronous): both queues empty, initial hash values loaded, byte
// count and bit length cleared. The block takes requests as soon as reset is released.
module sha256_byte_stream_hasher #(
  parameter int InDepth  = 4,
  parameter int OutDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  sha_pkg::in_item_t  in_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output sha_pkg::out_item_t out_o
);
  import sha_pkg::*;

  localparam int InW  = $bits(in_item_t);
  localparam int OutW = $bits(out_item_t);

  logic            keep, in_empty, in_pop, out_full, out_push, core_start;
  logic [InW-1:0]  in_rdata;
  logic [OutW-1:0] out_rdata;
  in_item_t        in_item;
  out_item_t       out_item;
  blk_t            block;
  hash_t           chain, vars;
  core_stat_t      core_stat;

  assign keep = in_i.kind inside {KIND_BYTE, KIND_BYTE_FIN, KIND_FIN};

  sha_fifo #(.Width(InW), .Depth(InDepth)) u_in_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push && keep),
    .data_i  (InW'(in_i)),
    .full_o  (full),
    .pop_i   (in_pop),
    .data_o  (in_rdata),
    .empty_o (in_empty)
  );

  assign in_item = in_item_t'(in_rdata);

  sha_engine u_engine (
    .clk_i,
    .rst_ni,
    .in_valid_i   (!in_empty),
    .in_item_i    (in_item),
    .in_pop_o     (in_pop),
    .core_start_o (core_start),
    .block_o      (block),
    .chain_o      (chain),
    .vars_i       (vars),
    .core_stat_i  (core_stat),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_item_o   (out_item)
  );

  sha_core u_core (
    .clk_i,
    .rst_ni,
    .start_i (core_start),
    .block_i (block),
    .chain_i (chain),
    .vars_o  (vars),
    .stat_o  (core_stat)
  );

  sha_fifo #(.Width(OutW), .Depth(OutDepth)) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .data_i  (OutW'(out_item)),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign out_o = out_item_t'(out_rdata);

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_pop |-> !in_empty)
    else $error("engine took a request from an empty input queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_push |-> !out_full)
    else $error("engine pushed a result into a full result queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) core_start |-> !core_stat.busy)
    else $error("round unit restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) core_stat.done |-> !core_stat.busy)
    else $error("round unit flagged done while still busy");
`endif

endmodule

[verif/sha256_byte_stream_hasher_tb.sv]
// Self-checking testbench of the SHA-256 byte stream hasher against a local SHA-256 model.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb;
  import sha_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_REQUESTS = 100;
  localparam int RANDOM_MESSAGES = 2;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_COIN,
    POP_SPARSE,
    POP_PERIODIC
  } pop_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  in_item_t  in_i = '0;
  logic      full;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_o;

  logic [31:0] hash_state [8];
  logic [31:0] block_buf [16];
  logic [5:0]  block_fill;
  logic [63:0] msg_bits;
  out_item_t   digest_q [$];
  out_item_t   want;

  int cycle_cnt = 0;
  int n_errors = 0;
  int n_words = 0;
  int n_requests = 0;
  int n_unused = 0;
  int n_messages = 0;
  int burst_left = 0;

  pop_mode_e   pop_mode = POP_ALWAYS;
  int          pop_span = 0;
  logic [7:0]  pop_phase = '0;

  sha256_byte_stream_hasher u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .in_i  (in_i),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .out_o (out_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void clear_hash_state();
    hash_state = SHA_IV;
    block_buf = '{default: '0};
    block_fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = block_buf[t];
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    block_buf = '{default: '0};
    block_fill = '0;
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    block_buf[block_fill[5:2]] |= {24'd0, b} << (8 * (3 - block_fill[1:0]));
    block_fill = block_fill + 6'd1;
  endfunction

  function automatic void predict_digest(input in_item_t req);
    out_item_t dw;
    if (req.kind == KIND_NOP) return;
    if (req.kind != KIND_FIN) begin
      load_byte(req.data_byte);
      msg_bits = msg_bits + 64'd8;
      if (block_fill == 6'd0) compress_block();
    end
    if (req.kind == KIND_BYTE) return;
    load_byte(8'h80);
    if (block_fill == 6'd0 || block_fill > 6'd56) compress_block();
    block_buf[14] = msg_bits[63:32];
    block_buf[15] = msg_bits[31:0];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      dw.digest_word = hash_state[i];
      dw.word_index = 3'(i);
      dw.last_word = (i == 7);
      digest_q.push_back(dw);
    end
    n_messages++;
    clear_hash_state();
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [7:0] data);
    in_item_t req;
    int gap;
    req.kind = kind;
    req.data_byte = data;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        in_i <= 10'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_i <= req;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_digest(req);
    n_requests++;
    if (kind == KIND_NOP) n_unused++;
  endtask

  task automatic send_message(input int len, input bit sep_fin, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_request(KIND_NOP, 8'($urandom));
      send_request((i == len - 1 && !sep_fin) ? KIND_BYTE_FIN : KIND_BYTE, 8'($urandom));
    end
    if (len == 0 || sep_fin) send_request(KIND_FIN, 8'($urandom));
  endtask

  task automatic test_directed_messages();
    send_request(KIND_FIN, 8'h5a);
    send_request(KIND_NOP, 8'hff);
    send_request(KIND_FIN, 8'h00);
    send_request(KIND_BYTE_FIN, 8'h00);
    send_request(KIND_BYTE_FIN, 8'hff);
    send_request(KIND_BYTE, 8'h61);
    send_request(KIND_NOP, 8'h00);
    send_request(KIND_BYTE, 8'h62);
    send_request(KIND_BYTE_FIN, 8'h63);
    send_request(KIND_BYTE, 8'hff);
    send_request(KIND_BYTE, 8'h00);
    send_request(KIND_FIN, 8'hff);
  endtask

  task automatic test_padding_boundaries();
    int lens [5] = '{55, 56, 63, 64, 119};
    foreach (lens[i]) send_message(lens[i], 1'($urandom), 1'b0);
  endtask

  task automatic test_random_stream();
    int base_req;
    int base_nop;
    int base_msg;
    int r;
    int len;
    base_req = n_requests;
    base_nop = n_unused;
    base_msg = n_messages;
    while ((n_requests - base_req) - (n_unused - base_nop) < RANDOM_REQUESTS ||
           n_messages - base_msg < RANDOM_MESSAGES) begin
      r = $urandom_range(0, 19);
      if (r < 14) len = $urandom_range(0, 70);
      else if (r < 18) len = $urandom_range(71, 140);
      else len = 64 * $urandom_range(0, 2) + $urandom_range(54, 66);
      send_message(len, 1'($urandom), 1'b1);
    end
  endtask

  // Receiver stalls: switch pop behavior whenever a randomly drawn span runs out.
  always @(posedge clk_i) begin
    if (pop_span == 0) begin
      pop_mode <= pop_mode_e'($urandom_range(0, 3));
      pop_span <= $urandom_range(16, 96);
    end else begin
      pop_span <= pop_span - 1;
    end
    pop_phase <= pop_phase + 8'd1;
    case (pop_mode)
      POP_ALWAYS: begin
        pop <= 1'b1;
      end
      POP_COIN: begin
        pop <= 1'($urandom);
      end
      POP_SPARSE: begin
        pop <= ($urandom_range(0, 4) == 0);
      end
      default: begin
        pop <= pop_phase[2];
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && pop && !empty) begin
      n_words++;
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h (index %0d)", out_o.digest_word, out_o.word_index);
        n_errors++;
      end else begin
        want = digest_q.pop_front();
        if (out_o.digest_word !== want.digest_word) begin
          $error("digest_word mismatch: expected %h, got %h",
                 want.digest_word, out_o.digest_word);
          n_errors++;
        end
        if (out_o.word_index !== want.word_index) begin
          $error("word_index mismatch: expected %0d, got %0d",
                 want.word_index, out_o.word_index);
          n_errors++;
        end
        if (out_o.last_word !== want.last_word) begin
          $error("last_word mismatch: expected %0b, got %0b",
                 want.last_word, out_o.last_word);
          n_errors++;
        end
      end
    end
  end

  initial begin
    clear_hash_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_messages();
    test_padding_boundaries();
    test_random_stream();
    push <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Hashed %0d messages from %0d requests (%0d of the unused kind),",
             n_messages, n_requests, n_unused);
    $display("empty and padding-edge lengths included; %0d digest words checked.", n_words);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/sha_pkg.sv
design/sha_fifo.sv
design/sha_core.sv
design/sha_engine.sv
design/sha256_byte_stream_hasher.sv
verif/sha256_byte_stream_hasher_tb.sv
